[hdl/itp_pkg.sv]
// Shared types, character codes and helper functions for the infix to prefix converter.
package itp_pkg;

    // Default buffer and stack depth
    localparam int C_MAX_LEN = 64;

    // Character codes
    localparam logic [7:0] C_CARET  = 8'h5E; // '^'
    localparam logic [7:0] C_SLASH  = 8'h2F; // '/'
    localparam logic [7:0] C_STAR   = 8'h2A; // '*'
    localparam logic [7:0] C_PLUS   = 8'h2B; // '+'
    localparam logic [7:0] C_MINUS  = 8'h2D; // '-'
    localparam logic [7:0] C_LPAREN = 8'h28; // '('
    localparam logic [7:0] C_RPAREN = 8'h29; // ')'
    localparam logic [7:0] C_LOW_A  = 8'h61; // 'a'
    localparam logic [7:0] C_LOW_Z  = 8'h7A; // 'z'
    localparam logic [7:0] C_UP_A   = 8'h41; // 'A'
    localparam logic [7:0] C_UP_Z   = 8'h5A; // 'Z'

    // Input item
    typedef struct packed {
        logic [7:0] char_in;
        logic       last_in;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic [7:0] char_out;
        logic       last_out;
        logic       is_empty;
        logic       overflowed;
    } t_out_item;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;       // store the input item character
        logic fetch;      // read the next character of the backward scan
        logic emit_ch;    // append the scanned character to the output buffer
        logic emit_top;   // append the stack top to the output buffer
        logic push;       // push the scanned character
        logic pop;        // drop the stack top
        logic adv;        // step the scan index back by one
        logic out_first;  // read the last output buffer entry
        logic out_step;   // present one result, read the entry before it
        logic out_empty;  // present the empty result
        logic finish;     // clear the overflow flag
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic is_letter;
        logic is_lparen;
        logic is_rparen;
        logic pops;        // stack top must be popped before the scanned operator
        logic depth_zero;
        logic top_rparen;
        logic idx_one;     // scan index is on the first character
        logic ocnt_zero;
        logic ocnt_one;
    } t_stat;

    // Operator precedence, -1 for anything that is not an operator
    function automatic logic signed [2:0] op_rank(input logic [7:0] ch);
        logic signed [2:0] r;
        r = -3'sd1;
        if (ch == C_CARET) begin
            r = 3'sd3;
        end else if (ch == C_STAR || ch == C_SLASH) begin
            r = 3'sd2;
        end else if (ch == C_PLUS || ch == C_MINUS) begin
            r = 3'sd1;
        end
        return r;
    endfunction

    // Letter test over both cases
    function automatic logic is_letter(input logic [7:0] ch);
        return (ch >= C_LOW_A && ch <= C_LOW_Z) || (ch >= C_UP_A && ch <= C_UP_Z);
    endfunction

endpackage

[hdl/infix_to_prefix_converter_unit.sv]
// Top level of the infix to prefix converter: controller, datapath and checks.
//
// Characters of an infix expression are taken one per cycle while busy is low; a
// character marked last starts the conversion and raises busy. The buffer is scanned
// from the end, each character being read, evaluated and its index stepped, with an
// extra evaluation for every operator the scan pops to the output, all bound by the
// single read port of the input buffer and stack memories; the stack is then flushed at
// one operator a cycle. Once the output buffer is opened, the prefix form comes out at
// one result per cycle with o_valid high for exactly one cycle each, the last one
// flagged; an empty result gives a single item with is_empty set. The receiver cannot
// stall, so every strobe must be taken. The final strobe comes in the first cycle after
// busy falls. Buffers and stack hold MAX_LEN entries; characters beyond that are
// dropped and every result of that expression carries the overflowed flag.
module infix_to_prefix_converter_unit import itp_pkg::*; #(
    parameter int MAX_LEN = C_MAX_LEN
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  t_in_item  i_item,
    output logic      busy,
    output logic      o_valid,
    output t_out_item o_item
);

    t_cmd  w_cmd;
    t_stat w_stat;

    // Sequence the scan, flush and read-out
    itp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_last  (i_item.last_in),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .busy    (busy)
    );

    // Hold the buffers, stack and result register
    itp_dpath #(
        .MAX_LEN (MAX_LEN)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat),
        .o_valid (o_valid),
        .o_item  (o_item)
    );

    // Busy only ever rises after a last character was taken
    a_busy_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start && i_item.last_in))
        else $error("busy rose without a last item");

    // A result strobe follows a busy cycle
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result strobe outside a conversion");

    // An empty result is the only and final result
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_item.is_empty) |-> o_item.last_out)
        else $error("empty result not marked last");

    // Nothing follows the final result
    a_last_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_item.last_out) |=> !o_valid)
        else $error("result strobe after the final result");

endmodule

[hdl/itp_ctrl.sv]
// Controller state machine for the infix to prefix converter.
module itp_ctrl import itp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  start,
    input  logic  i_last,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_EVAL,
        S_ADV,
        S_FLUSH,
        S_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_busy;

    // Decode state and status into commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    if (i_last) begin
                        n_state = S_FETCH;
                    end
                end
            end
            S_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state     = S_EVAL;
            end
            S_EVAL: begin
                priority if (i_stat.is_letter) begin
                    o_cmd.emit_ch = 1'b1;
                    n_state       = S_ADV;
                end else if (i_stat.is_rparen) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_ADV;
                end else if (i_stat.is_lparen) begin
                    priority if (!i_stat.depth_zero && !i_stat.top_rparen) begin
                        o_cmd.emit_top = 1'b1;
                        o_cmd.pop      = 1'b1;
                    end else if (!i_stat.depth_zero) begin
                        o_cmd.pop = 1'b1;
                        n_state   = S_ADV;
                    end else begin
                        n_state = S_ADV;
                    end
                end else begin
                    if (i_stat.pops) begin
                        o_cmd.emit_top = 1'b1;
                        o_cmd.pop      = 1'b1;
                    end else begin
                        o_cmd.push = 1'b1;
                        n_state    = S_ADV;
                    end
                end
            end
            S_ADV: begin
                o_cmd.adv = 1'b1;
                n_state   = i_stat.idx_one ? S_FLUSH : S_FETCH;
            end
            S_FLUSH: begin
                priority if (!i_stat.depth_zero) begin
                    o_cmd.emit_top = 1'b1;
                    o_cmd.pop      = 1'b1;
                end else if (i_stat.ocnt_zero) begin
                    o_cmd.out_empty = 1'b1;
                    o_cmd.finish    = 1'b1;
                    n_state         = S_IDLE;
                end else begin
                    o_cmd.out_first = 1'b1;
                    n_state         = S_OUT;
                end
            end
            S_OUT: begin
                o_cmd.out_step = 1'b1;
                if (i_stat.ocnt_one) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and the busy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
        end
    end

    assign busy = r_busy;

endmodule

[hdl/itp_dpath.sv]
// Datapath of the infix to prefix converter: buffers, operator stack, counters, result register.
module itp_dpath import itp_pkg::*; #(
    parameter int MAX_LEN = C_MAX_LEN
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_item,
    input  t_cmd      i_cmd,
    output t_stat     o_stat,
    output logic      o_valid,
    output t_out_item o_item
);

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW = $clog2(MAX_LEN + 1);

    logic [7:0]    r_ibuf [MAX_LEN];
    logic [7:0]    r_stack [MAX_LEN];
    logic [7:0]    r_obuf [MAX_LEN];

    logic [CW-1:0] r_icnt;
    logic [CW-1:0] r_depth;
    logic [CW-1:0] r_ocnt;
    logic          r_ovf;
    logic [7:0]    r_ch;
    logic [7:0]    r_top;
    logic [7:0]    r_obuf_q;
    logic          r_res_vld;
    t_out_item     r_res;

    logic [CW-1:0]     w_iaddr_rd;
    logic [CW-1:0]     w_saddr_rd;
    logic [CW-1:0]     w_oaddr_rd;
    logic [7:0]        w_emit_data;
    logic              w_emit;
    logic              w_icnt_room;
    logic              w_depth_room;
    logic              w_ocnt_room;
    logic signed [2:0] w_rank_ch;
    logic signed [2:0] w_rank_top;

    // Address and room arithmetic
    assign w_iaddr_rd   = r_icnt - CW'(1);
    assign w_saddr_rd   = r_depth - CW'(2);
    assign w_oaddr_rd   = i_cmd.out_first ? (r_ocnt - CW'(1)) : (r_ocnt - CW'(2));
    assign w_icnt_room  = (r_icnt < CW'(MAX_LEN));
    assign w_depth_room = (r_depth < CW'(MAX_LEN));
    assign w_ocnt_room  = (r_ocnt < CW'(MAX_LEN));
    assign w_emit       = i_cmd.emit_ch | i_cmd.emit_top;
    assign w_emit_data  = i_cmd.emit_top ? r_top : r_ch;

    // Classify the scanned character against the stack top
    assign w_rank_ch  = op_rank(r_ch);
    assign w_rank_top = op_rank(r_top);

    always_comb begin
        o_stat            = '0;
        o_stat.is_letter  = is_letter(r_ch);
        o_stat.is_lparen  = (r_ch == C_LPAREN);
        o_stat.is_rparen  = (r_ch == C_RPAREN);
        o_stat.depth_zero = (r_depth == '0);
        o_stat.top_rparen = (r_top == C_RPAREN);
        o_stat.idx_one    = (r_icnt == CW'(1));
        o_stat.ocnt_zero  = (r_ocnt == '0);
        o_stat.ocnt_one   = (r_ocnt == CW'(1));
        if (r_ch == C_CARET) begin
            o_stat.pops = (r_depth != '0) && (w_rank_top >= w_rank_ch);
        end else begin
            o_stat.pops = (r_depth != '0) && (w_rank_top > w_rank_ch);
        end
    end

    // Input buffer: store on load, read backward during the scan
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && w_icnt_room) begin
            r_ibuf[r_icnt[AW-1:0]] <= i_item.char_in;
        end
        if (i_cmd.fetch) begin
            r_ch <= r_ibuf[w_iaddr_rd[AW-1:0]];
        end
    end

    // Operator stack: the top is kept in a register, reloaded from memory on pop
    always_ff @(posedge i_clk) begin
        if (i_cmd.push && w_depth_room) begin
            r_stack[r_depth[AW-1:0]] <= r_ch;
            r_top                    <= r_ch;
        end else if (i_cmd.pop) begin
            r_top <= r_stack[w_saddr_rd[AW-1:0]];
        end
    end

    // Output buffer: append during the scan, read back in reverse
    always_ff @(posedge i_clk) begin
        if (w_emit && w_ocnt_room) begin
            r_obuf[r_ocnt[AW-1:0]] <= w_emit_data;
        end
        if (i_cmd.out_first || i_cmd.out_step) begin
            r_obuf_q <= r_obuf[w_oaddr_rd[AW-1:0]];
        end
    end

    // Counters and overflow flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_icnt  <= '0;
            r_depth <= '0;
            r_ocnt  <= '0;
            r_ovf   <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                if (w_icnt_room) begin
                    r_icnt <= r_icnt + CW'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
            end else if (i_cmd.adv) begin
                r_icnt <= r_icnt - CW'(1);
            end
            if (i_cmd.push && w_depth_room) begin
                r_depth <= r_depth + CW'(1);
            end else if (i_cmd.pop) begin
                r_depth <= r_depth - CW'(1);
            end
            if (w_emit && w_ocnt_room) begin
                r_ocnt <= r_ocnt + CW'(1);
            end else if (i_cmd.out_step) begin
                r_ocnt <= r_ocnt - CW'(1);
            end
            if (i_cmd.finish) begin
                r_ovf <= 1'b0;
            end
        end
    end

    // Result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_vld <= 1'b0;
        end else begin
            r_res_vld <= i_cmd.out_step | i_cmd.out_empty;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_step) begin
            r_res.char_out   <= r_obuf_q;
            r_res.last_out   <= (r_ocnt == CW'(1));
            r_res.is_empty   <= 1'b0;
            r_res.overflowed <= r_ovf;
        end else if (i_cmd.out_empty) begin
            r_res.char_out   <= '0;
            r_res.last_out   <= 1'b1;
            r_res.is_empty   <= 1'b1;
            r_res.overflowed <= r_ovf;
        end
    end

    assign o_valid = r_res_vld;
    assign o_item  = r_res;

endmodule
